>>> hdl/aos_pkg.sv
// Shared types and constants for the alternating order search core.
package aos_pkg;

    localparam int DEPTH_DEFAULT     = 64;
    localparam int WORD_BITS_DEFAULT = 32;

    localparam int INDEX_W = 6;   // load_index and match_index width
    localparam int FIELD_W = 32;  // write_value and search_key width
    localparam int CNT_W   = 7;   // entry_count width
    localparam int RANK_W  = 7;   // rank bounds, 0..64
    localparam int POS_W   = 7;   // array position, 0..127

    localparam int MAX_COUNT = 127;

    localparam logic [CNT_W-1:0] ENTRY_COUNT_RESET = 7'd64;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic probe;
        logic check;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic out_free;
    } status_t;

endpackage

>>> hdl/aos_datapath.sv
// Datapath: entry memory, two rank-search lanes, config and output registers.
module aos_datapath
    import aos_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic                      cfg_wr_en,
    input  logic        [CNT_W-1:0]   cfg_wr_data,
    input  logic        [INDEX_W-1:0] s_load_index,
    input  logic signed [FIELD_W-1:0] s_write_value,
    input  logic signed [FIELD_W-1:0] s_search_key,
    input  logic                      m_ready,
    output logic                      m_valid,
    output logic                      m_found,
    output logic        [INDEX_W-1:0] m_match_index
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CLAMP  = (DEPTH < MAX_COUNT) ? DEPTH : MAX_COUNT;
    localparam logic [CNT_W-1:0] CLAMP_C = CNT_W'(CLAMP);

    logic [WORD_BITS-1:0] mem_reg [DEPTH];
    logic [WORD_BITS-1:0] rd_reg  [2];

    logic [CNT_W-1:0]     entry_count_reg, entry_count_next;
    logic [WORD_BITS-1:0] key_reg, key_next;
    logic [RANK_W-1:0]    low_reg  [2], low_next  [2];
    logic [RANK_W-1:0]    high_reg [2], high_next [2];
    logic [POS_W-1:0]     pos_reg  [2], pos_next  [2];
    logic [1:0]           act_reg, act_next;
    logic [1:0]           hit_reg, hit_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 m_found_reg, m_found_next;
    logic [INDEX_W-1:0]   m_index_reg, m_index_next;

    logic [RANK_W-1:0]    mid      [2];
    logic [RANK_W-1:0]    mid_inc  [2];
    logic [POS_W-1:0]     probe_pos[2];
    logic [ADDR_W-1:0]    rd_addr  [2];
    logic [1:0]           eq, go_up;

    logic [CNT_W-1:0]     n_eff;
    logic [RANK_W-1:0]    even_cnt, odd_cnt;
    logic                 wr_ok;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 odd_wins;

    assign wr_ok   = int'(s_load_index) < DEPTH;
    assign wr_addr = ADDR_W'(s_load_index);

    // Positions past the array are never searched
    assign n_eff    = (entry_count_reg > CLAMP_C) ? CLAMP_C : entry_count_reg;
    assign even_cnt = RANK_W'(({1'b0, n_eff} + (CNT_W+1)'(1)) >> 1);
    assign odd_cnt  = RANK_W'(n_eff >> 1);

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            mid[l]       = low_reg[l] + ((high_reg[l] - low_reg[l]) >> 1);
            mid_inc[l]   = mid[l] + RANK_W'(1);
            probe_pos[l] = {mid[l][POS_W-2:0], 1'(l)};
            rd_addr[l]   = ADDR_W'(probe_pos[l]);
            eq[l]        = (rd_reg[l] == key_reg);
        end
        // even lane ascends, odd lane descends
        go_up[0] = $signed(rd_reg[0]) < $signed(key_reg);
        go_up[1] = $signed(rd_reg[1]) > $signed(key_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && wr_ok) begin
            mem_reg[wr_addr] <= WORD_BITS'($unsigned(s_write_value));
        end
        if (cmd.probe) begin
            rd_reg[0] <= mem_reg[rd_addr[0]];
            rd_reg[1] <= mem_reg[rd_addr[1]];
        end
    end

    assign odd_wins = hit_reg[1] && (!hit_reg[0] || (pos_reg[1] > pos_reg[0]));

    always_comb begin
        entry_count_next = entry_count_reg;
        key_next         = key_reg;
        act_next         = act_reg;
        hit_next         = hit_reg;
        for (int l = 0; l < 2; l++) begin
            low_next[l]  = low_reg[l];
            high_next[l] = high_reg[l];
            pos_next[l]  = pos_reg[l];
        end
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_index_next = m_index_reg;

        if (cfg_wr_en) begin
            entry_count_next = cfg_wr_data;
        end

        if (cmd.start) begin
            key_next     = WORD_BITS'($unsigned(s_search_key));
            low_next[0]  = '0;
            low_next[1]  = '0;
            high_next[0] = even_cnt;
            high_next[1] = odd_cnt;
            act_next[0]  = (even_cnt != '0);
            act_next[1]  = (odd_cnt != '0);
            hit_next     = '0;
        end else if (cmd.check) begin
            for (int l = 0; l < 2; l++) begin
                if (act_reg[l]) begin
                    if (eq[l]) begin
                        hit_next[l] = 1'b1;
                        pos_next[l] = probe_pos[l];
                        act_next[l] = 1'b0;
                    end else if (go_up[l]) begin
                        low_next[l] = mid_inc[l];
                        act_next[l] = (mid_inc[l] < high_reg[l]);
                    end else begin
                        high_next[l] = mid[l];
                        act_next[l]  = (low_reg[l] < mid[l]);
                    end
                end
            end
        end

        if (cmd.publish) begin
            m_valid_next = 1'b1;
            m_found_next = |hit_reg;
            if (odd_wins) begin
                m_index_next = pos_reg[1][INDEX_W-1:0];
            end else if (hit_reg[0]) begin
                m_index_next = pos_reg[0][INDEX_W-1:0];
            end else begin
                m_index_next = '0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= ENTRY_COUNT_RESET;
            act_reg         <= '0;
            hit_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            entry_count_reg <= entry_count_next;
            act_reg         <= act_next;
            hit_reg         <= hit_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        low_reg     <= low_next;
        high_reg    <= high_next;
        pos_reg     <= pos_next;
        m_found_reg <= m_found_next;
        m_index_reg <= m_index_next;
    end

    assign status.busy     = |act_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_match_index = m_index_reg;

endmodule

>>> hdl/aos_ctrl.sv
// Controller: sequences load, probe/check rounds and result hand-off.
module aos_ctrl
    import aos_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_req_type,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && (s_req_type == REQ_SEARCH)) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                state_next = status.busy ? ST_CHECK : ST_DONE;
            end
            ST_CHECK: begin
                state_next = ST_PROBE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.load  = s_valid && (s_req_type == REQ_LOAD);
                cmd.start = s_valid && (s_req_type == REQ_SEARCH);
            end
            ST_PROBE: begin
                cmd.probe = status.busy;
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
            end
            ST_DONE: begin
                cmd.publish = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/alternating_order_search_core.sv
// A load transaction gives no result. A search runs probe/check rounds until both lanes are
// done (at most 6 probe rounds for 64 entries, 32 ranks per lane), then waits for a free result register;
// even and odd lanes probe the memory's two read ports at once.
// Throughput: one load per cycle while the controller is idle; a new search is taken only
// after the previous one has reached the result register and the controller is back in idle.
// Reset (aresetn, sync, active low): control cleared, entry_count = 64; memory undefined.
module alternating_order_search_core
    import aos_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // entry_count register write
    input  logic                      cfg_wr_en,
    input  logic        [CNT_W-1:0]   cfg_wr_data,
    // request transactions
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic        [INDEX_W-1:0] s_load_index,
    input  logic signed [FIELD_W-1:0] s_write_value,
    input  logic signed [FIELD_W-1:0] s_search_key,
    // result transactions
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_found,
    output logic        [INDEX_W-1:0] m_match_index
);

    cmd_t    cmd;
    status_t status;

    // Controller: idle / probe / check / done; requests are taken only in idle,
    // while a finished result may still sit in the output register.
    aos_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath: entry memory (one write, two registered reads), one binary
    // search lane per parity, and the result register. The larger matching
    // position wins when both lanes hit.
    aos_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_load_index  (s_load_index),
        .s_write_value (s_write_value),
        .s_search_key  (s_search_key),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_found       (m_found),
        .m_match_index (m_match_index)
    );

endmodule

>>> tb/tb_alternating_order_search_core.sv
// Testbench for alternating_order_search_core: tables, searches and checks against a predictor.
`timescale 1ns / 100ps

module tb_alternating_order_search_core
    import aos_pkg::*;
();

    // Run control
    localparam int LONG_HOLD     = 300;   // receiver hold-off during the pressure test
    localparam int SETTLE_CYCLES = 32;    // longer than one full search plus output
    localparam int DRAIN_CYCLES  = 40;
    localparam int QUIET_LIMIT   = 5000;  // cycles without any transaction before giving up

    localparam logic signed [FIELD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    typedef enum int {
        TABLE_EXTREMES,
        TABLE_SPREAD,
        TABLE_DUPLICATES
    } table_mode_t;

    typedef struct {
        logic                      req;
        logic        [INDEX_W-1:0] idx;
        logic signed [FIELD_W-1:0] value;
        logic signed [FIELD_W-1:0] key;
    } request_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
    } lookup_t;

    // DUT signals
    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic        [CNT_W-1:0]   cfg_wr_data;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_req_type;
    logic        [INDEX_W-1:0] s_load_index;
    logic signed [FIELD_W-1:0] s_write_value;
    logic signed [FIELD_W-1:0] s_search_key;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_found;
    logic        [INDEX_W-1:0] m_match_index;

    // Predictor state: mirror of the entry memory and of the count register
    logic signed [FIELD_W-1:0] entry_mem [DEPTH_DEFAULT];
    logic        [CNT_W-1:0]   count_setting = ENTRY_COUNT_RESET;

    lookup_t results_due [$];   // predicted search results, oldest first
    int      mismatch_count = 0;
    int      results_seen   = 0;
    bit      idle_on        = 1'b1;   // random idle bursts on both channels
    int      hold_requests  = 0;      // bumped by a test to ask the sink for a long hold-off
    int      quiet_cycles   = 0;

    alternating_order_search_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_load_index  (s_load_index),
        .s_write_value (s_write_value),
        .s_search_key  (s_search_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_match_index (m_match_index)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    // Positions covered by a search: the count register, clipped to the depth.
    function automatic int searched_span();
        return (int'(count_setting) > DEPTH_DEFAULT) ? DEPTH_DEFAULT : int'(count_setting);
    endfunction

    // Plain binary search over ranks 0..ranks-1 of positions 2*rank+odd.
    // Even lane rises, odd lane falls; midpoint rounds down.
    function automatic void probe_lane(input bit odd, input int ranks,
                                       input logic signed [FIELD_W-1:0] key,
                                       output bit hit, output int pos);
        int lo, hi, mid, p;
        lo  = 0;
        hi  = ranks;
        hit = 1'b0;
        pos = 0;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            p   = 2 * mid + int'(odd);
            if (entry_mem[p] == key) begin
                hit = 1'b1;
                pos = p;
                return;
            end
            if (odd ? (entry_mem[p] > key) : (entry_mem[p] < key))
                lo = mid + 1;
            else
                hi = mid;
        end
    endfunction

    // Larger matching position of the two lanes wins.
    function automatic lookup_t predict_search(input logic signed [FIELD_W-1:0] key);
        lookup_t res;
        bit      even_hit, odd_hit;
        int      even_pos, odd_pos, n;
        n = searched_span();
        probe_lane(1'b0, (n + 1) / 2, key, even_hit, even_pos);
        probe_lane(1'b1, n / 2, key, odd_hit, odd_pos);
        if (odd_hit && (!even_hit || odd_pos > even_pos))
            res = '{found: 1'b1, index: INDEX_W'(odd_pos)};
        else if (even_hit)
            res = '{found: 1'b1, index: INDEX_W'(even_pos)};
        else
            res = '{found: 1'b0, index: '0};
        return res;
    endfunction

    //------------------------------------------------------------------
    // Sender side
    //------------------------------------------------------------------

    // Offer one transaction; the predictor is updated at the accepting edge.
    // Called and returns at a falling edge; valid stays high for the next item.
    task automatic send_item(input request_t r);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req_type    = r.req;
        s_load_index  = r.idx;
        s_write_value = r.value;
        s_search_key  = r.key;
        s_valid       = 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (r.req == REQ_LOAD)
            entry_mem[r.idx] = r.value;
        else
            results_due.push_back(predict_search(r.key));
        @(negedge aclk);
    endtask

    // Unused fields carry random filler so every payload bit toggles.
    task automatic load_word(input int idx, input logic signed [FIELD_W-1:0] value);
        request_t r;
        r = '{req: REQ_LOAD, idx: INDEX_W'(idx), value: value, key: $urandom};
        send_item(r);
    endtask

    task automatic search_for(input logic signed [FIELD_W-1:0] key);
        request_t r;
        r = '{req: REQ_SEARCH, idx: INDEX_W'($urandom), value: $urandom, key: key};
        send_item(r);
    endtask

    // Count register is only touched with the core idle: all results back,
    // then a settle window for any load still in flight.
    task automatic set_entry_count(input logic [CNT_W-1:0] value);
        s_valid = 1'b0;
        while (results_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en     = 1'b0;
        count_setting = value;
    endtask

    function automatic void sort_rising(ref logic signed [FIELD_W-1:0] w [32]);
        logic signed [FIELD_W-1:0] v;
        int j;
        for (int i = 1; i < 32; i++) begin
            v = w[i];
            j = i - 1;
            while (j >= 0 && w[j] > v) begin
                w[j + 1] = w[j];
                j--;
            end
            w[j + 1] = v;
        end
    endfunction

    // Writes all 64 entries, even lane rising and odd lane falling, in shuffled order.
    task automatic load_ordered_table(input table_mode_t mode);
        logic signed [FIELD_W-1:0] rise [32];
        logic signed [FIELD_W-1:0] fall [32];
        int order [DEPTH_DEFAULT];
        int j, t, p;
        for (int i = 0; i < 32; i++) begin
            if (mode == TABLE_DUPLICATES) begin
                rise[i] = int'($urandom_range(0, 6)) - 3;
                fall[i] = int'($urandom_range(0, 6)) - 3;
            end else begin
                rise[i] = $urandom;
                fall[i] = $urandom;
            end
        end
        sort_rising(rise);
        sort_rising(fall);
        if (mode == TABLE_EXTREMES) begin
            rise[0]  = WORD_MIN;
            rise[31] = WORD_MAX;
            fall[0]  = WORD_MIN;
            fall[31] = WORD_MAX;
        end
        for (int i = 0; i < DEPTH_DEFAULT; i++) order[i] = i;
        for (int i = DEPTH_DEFAULT - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < DEPTH_DEFAULT; i++) begin
            p = order[i];
            load_word(p, (p % 2) ? fall[31 - p / 2] : rise[p / 2]);
        end
    endtask

    // Mostly keys present in the searched window, some near misses and
    // keys from outside the window, some fully random.
    function automatic logic signed [FIELD_W-1:0] pick_key();
        int n, k;
        n = searched_span();
        k = $urandom_range(0, 9);
        if (n > 0 && k < 6)
            return entry_mem[$urandom_range(0, n - 1)];
        else if (n > 0 && k < 8)
            return entry_mem[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        else if (k == 8)
            return entry_mem[$urandom_range(0, DEPTH_DEFAULT - 1)];
        return $urandom;
    endfunction

    // One random transaction. An ordered load copies a same-lane neighbor,
    // so the lanes stay monotonic; a broken load writes anything anywhere.
    task automatic random_item(input bit broken);
        int p, nb;
        if ($urandom_range(0, 9) < 2) begin
            p = $urandom_range(0, DEPTH_DEFAULT - 1);
            if (broken) begin
                load_word(p, $urandom);
            end else begin
                if (p < 2)
                    nb = p + 2;
                else if (p > DEPTH_DEFAULT - 3)
                    nb = p - 2;
                else
                    nb = $urandom_range(0, 1) ? p + 2 : p - 2;
                load_word(p, entry_mem[nb]);
            end
        end else begin
            search_for(pick_key());
        end
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Extremes table, searched at the count left by reset (no write yet).
    task automatic test_extremes_at_reset_count();
        load_ordered_table(TABLE_EXTREMES);
        search_for(WORD_MIN);          // at 0 and 63: odd lane wins
        search_for(WORD_MAX);          // at 62 and 1: even lane wins
        search_for(entry_mem[30]);
        search_for(entry_mem[33]);
        search_for(entry_mem[1] - 1);
        search_for(entry_mem[62] - 1);
        search_for(0);
        search_for(-1);
        search_for($urandom);
        load_word(40, entry_mem[42]);  // equal neighbors in the even lane
        search_for(entry_mem[40]);
    endtask

    // Count zero, the smallest counts and a count past the depth.
    task automatic test_count_limits();
        logic [CNT_W-1:0] counts [4];
        counts = '{7'd0, 7'd1, 7'd2, 7'd127};
        foreach (counts[i]) begin
            set_entry_count(counts[i]);
            search_for(entry_mem[0]);
            search_for(entry_mem[1]);
            search_for(WORD_MIN);
        end
    endtask

    task automatic test_random_phases();
        int               phase_counts [8];
        logic [CNT_W-1:0] cnt;
        phase_counts = '{64, 2, 127, 1, 65, 63, 0, 33};
        for (int ph = 0; ph < 8; ph++) begin
            cnt = (ph == 7) ? CNT_W'($urandom_range(3, 62)) : CNT_W'(phase_counts[ph]);
            set_entry_count(cnt);
            if (ph == 2)
                load_ordered_table(TABLE_DUPLICATES);
            else if (ph == 5)
                load_ordered_table(TABLE_SPREAD);
            idle_on = (ph != 4);   // one phase runs flat out
            repeat (36) random_item(ph == 6);
        end
        idle_on = 1'b1;
    endtask

    // Sink stalls for a long stretch while searches keep coming, so the core
    // backs up and drops s_ready.
    task automatic test_output_backpressure();
        set_entry_count(7'd64);
        idle_on = 1'b0;
        hold_requests++;
        repeat (16) search_for(pick_key());
        idle_on = 1'b1;
    endtask

    // Last part: no idling on either side.
    task automatic test_no_idle_tail();
        set_entry_count(CNT_W'($urandom_range(40, 64)));
        idle_on = 1'b0;
        repeat (40) random_item(1'b0);
    endtask

    //------------------------------------------------------------------
    // Result sink: random idle bursts plus requested long hold-offs
    //------------------------------------------------------------------
    initial begin : result_sink
        int burst_left;
        int hold_left;
        int holds_served;
        burst_left   = 0;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD - 1;
                m_ready   = 1'b0;
            end else if (burst_left > 0) begin
                m_ready = 1'b0;
                burst_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready    = 1'b0;
                burst_left = $urandom_range(0, 4);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    //------------------------------------------------------------------
    // Checking
    //------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : result_check
        lookup_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("result transaction %0d with nothing expected",
                                          results_seen));
            end else begin
                want = results_due.pop_front();
                if (m_found !== want.found)
                    report_mismatch($sformatf("result %0d found %b, expected %b",
                                              results_seen, m_found, want.found));
                if (m_match_index !== want.index)
                    report_mismatch($sformatf("result %0d match_index %0d, expected %0d",
                                              results_seen, m_match_index, want.index));
            end
        end
    end

    // Watchdog: any transaction on either channel counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_req_type    = REQ_LOAD;
        s_load_index  = '0;
        s_write_value = '0;
        s_search_key  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_extremes_at_reset_count();
        test_count_limits();
        test_random_phases();
        test_output_backpressure();
        test_no_idle_tail();

        s_valid = 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> alternating_order_search_core.f
hdl/aos_pkg.sv
hdl/aos_datapath.sv
hdl/aos_ctrl.sv
hdl/alternating_order_search_core.sv
tb/tb_alternating_order_search_core.sv
